FILE: rtl/wq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wait queue package
// Shared field widths, operation and status codes, channel payload types and
// the command group that passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package wq_pkg;

   localparam int DEFAULT_WAITERS = 16;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 2;
   localparam int QLEN_W   = 5;

   // Only slots that a waiter id can name are ever used.
   localparam int MAX_SLOTS = 1 << ID_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_TRANSFER = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOTHING   = 2'd1,
      STATUS_DUPLICATE = 2'd2
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   waiter_id;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   granted_id;
      logic [QLEN_W-1:0] queue_length;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/wq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/wq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wait queue controller
// Sequences each transaction through a capture cycle and an execute state that
// waits for a free result register, and owns the result valid flag.
// ----------------------------------------------------------------------------
module wq_ctrl
   import wq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   // The result register must be free, or freed in this cycle, to commit.
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EXEC)
      else $error("capture did not move the controller to execute");

   a_exec_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && rsp_valid_ff && !rsp_ready |=> state_ff == ST_EXEC)
      else $error("execute finished while the result register was occupied");

   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

endmodule
`default_nettype wire

FILE: rtl/wq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wait queue datapath
// Holds head, tail, count, queued flags and the two link tables, and
// computes the list update and the result of each transaction.
// ----------------------------------------------------------------------------
module wq_dp
   import wq_pkg::*;
#(
   parameter int WAITERS = DEFAULT_WAITERS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   localparam int SLOTS = (WAITERS < MAX_SLOTS) ? WAITERS : MAX_SLOTS;
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int ID_XW = ID_W + 1;

   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SW-1:0]     head_ff, head_in;
   logic [SW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]  flag_ff, flag_in;
   rsp_type           rsp_ff, rsp_in;

   logic [SW-1:0] rd_addr;
   logic [SW-1:0] next_rd, prev_rd;
   logic          next_we, prev_we;
   logic [SW-1:0] next_wa, next_wd, prev_wa, prev_wd;

   logic [SW-1:0] id_slot;
   logic          id_ok;
   logic          id_queued;

   // Cancel needs the links of the named slot, transfer those of the head.
   assign rd_addr = (req_data.kind == KIND_TRANSFER) ? head_ff : req_data.waiter_id[SW-1:0];

   wq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   wq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign id_slot   = id_ff[SW-1:0];
   assign id_ok     = ID_XW'(id_ff) < ID_XW'(SLOTS);
   assign id_queued = id_ok && flag_ff[id_slot];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      next_we  = 1'b0;
      next_wa  = tail_ff;
      next_wd  = id_slot;
      prev_we  = 1'b0;
      prev_wa  = id_slot;
      prev_wd  = tail_ff;
      rsp_in.status     = STATUS_NOTHING;
      rsp_in.granted_id = '0;

      case (kind_ff)
         KIND_ENQUEUE: begin
            if (id_queued) begin
               rsp_in.status = STATUS_DUPLICATE;
            end else if (id_ok) begin
               rsp_in.status    = STATUS_DONE;
               flag_in[id_slot] = 1'b1;
               count_in         = count_ff + CW'(1);
               tail_in          = id_slot;
               if (count_ff == '0) begin
                  head_in = id_slot;
               end else begin
                  next_we = 1'b1;
                  prev_we = 1'b1;
               end
            end
         end
         KIND_CANCEL: begin
            if (id_queued) begin
               rsp_in.status    = STATUS_DONE;
               flag_in[id_slot] = 1'b0;
               if (count_ff <= CW'(1)) begin
                  count_in = '0;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  count_in = count_ff - CW'(1);
                  if (head_ff == id_slot) begin
                     head_in = next_rd;
                  end else if (tail_ff == id_slot) begin
                     tail_in = prev_rd;
                  end else begin
                     // A middle waiter: join its neighbors to each other.
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = next_rd;
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = prev_rd;
                  end
               end
            end
         end
         KIND_TRANSFER: begin
            if (count_ff != '0) begin
               rsp_in.status     = STATUS_DONE;
               rsp_in.granted_id = ID_W'(head_ff);
               flag_in[head_ff]  = 1'b0;
               if (count_ff == CW'(1)) begin
                  count_in = '0;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  count_in = count_ff - CW'(1);
                  head_in  = next_rd;
               end
            end
         end
         default: begin
            rsp_in.status = STATUS_NOTHING;
         end
      endcase

      rsp_in.queue_length = QLEN_W'(count_in);

      if (!cmd.commit) begin
         next_we = 1'b0;
         prev_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         flag_ff  <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         id_ff   <= req_data.waiter_id;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_empty_resets_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with a nonzero head or tail");

   a_flags_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(flag_ff) == int'(count_ff))
      else $error("queued flags disagree with the waiter count");

endmodule
`default_nettype wire

FILE: rtl/fifo_waiter_queue_with_cancel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO waiter queue with cancel
// First-come queue of waiter slots kept as a doubly linked list.
//
// The req channel carries one operation per transaction: enqueue a waiter
// at the tail, cancel a queued waiter wherever it sits, or transfer the
// ticket to the head waiter. Every request yields exactly one rsp
// transaction with a status, the granted id and the queue length after it.
// An item passes through a capture cycle, which reads the next and previous
// link tables, and an execute step, which computes the update, writes the
// links and loads the result register. A new request is accepted again in
// the cycle following the commit, so the queue does not take a new request
// before it is through with the last one.
// If the receiver stalls, the finished result waits in the output register;
// one further request is accepted and then held in execute until the result
// is taken. Synchronous reset empties the queue and clears all queued flags;
// the link tables need no clearing and no request is refused after reset.
// ----------------------------------------------------------------------------
module fifo_waiter_queue_with_cancel
   import wq_pkg::*;
#(
   parameter int WAITERS = DEFAULT_WAITERS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;

   wq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   wq_dp #(.WAITERS(WAITERS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: tb/fifo_waiter_queue_with_cancel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO waiter queue with cancel testbench
// Drives enqueue, cancel, transfer and spare-kind requests through the req
// channel. Each response is checked field by field against a local model of
// the linked waiter list, or against the written-in result for the typed
// rows of the short directed script that opens the run. Random traffic follows,
// with fill, drain and balanced mixes, under four sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module fifo_waiter_queue_with_cancel_tb;
   import wq_pkg::*;

   localparam int WAITERS = DEFAULT_WAITERS;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } script_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Local copy of the waiter list.
   logic [ID_W-1:0]   next_of [WAITERS];
   logic [ID_W-1:0]   prev_of [WAITERS];
   logic              queued [WAITERS];
   logic [ID_W-1:0]   head_id;
   logic [ID_W-1:0]   tail_id;
   logic [QLEN_W-1:0] waiting;

   rsp_type   queue_op_results[$];
   script_row script[$];
   rsp_type   seen_rsp;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int accepted = 0;
   int idle_cycles = 0;
   int status_hits [3] = '{0, 0, 0};
   int longest = 0;
   int cancel_head = 0;
   int cancel_mid = 0;
   int cancel_tail = 0;

   fifo_waiter_queue_with_cancel #(
      .WAITERS(WAITERS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (queued[s]) begin
         queued[s] = 1'b0;
         next_of[s] = '0;
         prev_of[s] = '0;
      end
      head_id = '0;
      tail_id = '0;
      waiting = '0;
   end

   // Applies one request to the local list and returns the response it implies.
   function automatic rsp_type apply_queue_op(req_type r);
      rsp_type         o;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] nx;
      logic [ID_W-1:0] pv;
      id = r.waiter_id;
      o.status = STATUS_NOTHING;
      o.granted_id = '0;
      case (r.kind)
         KIND_ENQUEUE: begin
            if (queued[id]) begin
               o.status = STATUS_DUPLICATE;
            end else begin
               queued[id] = 1'b1;
               if (waiting == 0) begin
                  head_id = id;
                  tail_id = id;
               end else begin
                  next_of[tail_id] = id;
                  prev_of[id] = tail_id;
                  tail_id = id;
               end
               waiting = waiting + 1'b1;
               o.status = STATUS_DONE;
            end
         end
         KIND_CANCEL: begin
            if (queued[id]) begin
               queued[id] = 1'b0;
               o.status = STATUS_DONE;
               if (waiting <= 1) begin
                  waiting = '0;
                  head_id = '0;
                  tail_id = '0;
               end else begin
                  waiting = waiting - 1'b1;
                  nx = next_of[id];
                  pv = prev_of[id];
                  if (head_id == id) begin
                     head_id = nx;
                     cancel_head++;
                  end else if (tail_id == id) begin
                     tail_id = pv;
                     cancel_tail++;
                  end else begin
                     next_of[pv] = nx;
                     prev_of[nx] = pv;
                     cancel_mid++;
                  end
               end
            end
         end
         KIND_TRANSFER: begin
            if (waiting != 0) begin
               o.status = STATUS_DONE;
               o.granted_id = head_id;
               queued[head_id] = 1'b0;
               if (waiting == 1) begin
                  waiting = '0;
                  head_id = '0;
                  tail_id = '0;
               end else begin
                  waiting = waiting - 1'b1;
                  head_id = next_of[head_id];
               end
            end
         end
         default: ;
      endcase
      o.queue_length = waiting;
      return o;
   endfunction

   // Picks a slot whose queued flag matches want, or any slot if none does.
   function automatic logic [ID_W-1:0] pick_slot(logic want);
      logic [ID_W-1:0] pool[$];
      for (int s = 0; s < WAITERS; s++)
         if (queued[s] == want) pool.push_back(ID_W'(s));
      if (pool.size() == 0) return ID_W'($urandom_range(WAITERS - 1));
      return pool[$urandom_range(pool.size() - 1)];
   endfunction

   function automatic req_type random_item(int enq_w, int cancel_w, int xfer_w);
      req_type r;
      int      roll;
      roll = $urandom_range(99);
      r.waiter_id = ID_W'($urandom_range(WAITERS - 1));
      if (roll < enq_w) begin
         r.kind = KIND_ENQUEUE;
         if ($urandom_range(99) < 85) r.waiter_id = pick_slot(1'b0);
      end else if (roll < enq_w + cancel_w) begin
         r.kind = KIND_CANCEL;
         if ($urandom_range(99) < 80) r.waiter_id = pick_slot(1'b1);
      end else if (roll < enq_w + cancel_w + xfer_w) begin
         r.kind = KIND_TRANSFER;
      end else begin
         r.kind = KIND_SPARE;
      end
      return r;
   endfunction

   task automatic add_row(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, bit typed,
                          status_type st, logic [ID_W-1:0] gid,
                          logic [QLEN_W-1:0] len);
      script_row row;
      row.item.kind = kind;
      row.item.waiter_id = id;
      row.typed = typed;
      row.want.status = st;
      row.want.granted_id = gid;
      row.want.queue_length = len;
      script.push_back(row);
   endtask

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_item(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predicted = apply_queue_op(r);
      queue_op_results.push_back(typed ? typed_rsp : predicted);
      status_hits[predicted.status]++;
      if (int'(predicted.queue_length) > longest) longest = int'(predicted.queue_length);
      accepted++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (queue_op_results.size() != 0);
   endtask

   task automatic note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want,
                  got);
   endtask

   always @(posedge clock)
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

   // Outputs are sampled mid-cycle; a handshake seen here completes at the next edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (queue_op_results.size() == 0) begin
            note_mismatch("unexpected response transaction", 0, 1);
         end else begin
            seen_rsp = queue_op_results.pop_front();
            if (rsp_data.status != seen_rsp.status)
               note_mismatch("status", int'(seen_rsp.status), int'(rsp_data.status));
            if (rsp_data.granted_id != seen_rsp.granted_id)
               note_mismatch("granted_id", int'(seen_rsp.granted_id),
                             int'(rsp_data.granted_id));
            if (rsp_data.queue_length != seen_rsp.queue_length)
               note_mismatch("queue_length", int'(seen_rsp.queue_length),
                             int'(rsp_data.queue_length));
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int enq_w;
      int cancel_w;
      int xfer_w;
      int profile [4][2];

      profile = '{'{0, 0}, '{46, 0}, '{0, 46}, '{9, 9}};

      // Empty-queue cases, the first enqueue and its repeat can be read off directly.
      add_row(KIND_TRANSFER, 4'd15, 1'b1, STATUS_NOTHING, 4'd0, 5'd0);
      add_row(KIND_CANCEL,   4'd7,  1'b1, STATUS_NOTHING, 4'd0, 5'd0);
      add_row(KIND_SPARE,    4'd15, 1'b1, STATUS_NOTHING, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd0,  1'b1, STATUS_DONE,    4'd0, 5'd1);
      add_row(KIND_ENQUEUE,  4'd0,  1'b1, STATUS_DUPLICATE, 4'd0, 5'd1);
      add_row(KIND_ENQUEUE,  4'd15, 1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd5,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd9,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd3,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd10, 1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_SPARE,    4'd0,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      // Cancel at the head, at the tail, in the middle, then a slot not queued.
      add_row(KIND_CANCEL,   4'd0,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_CANCEL,   4'd10, 1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_CANCEL,   4'd5,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_CANCEL,   4'd5,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd5,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_TRANSFER, 4'd0,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      // The waiter just granted times out too late.
      add_row(KIND_CANCEL,   4'd15, 1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_TRANSFER, 4'd6,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_TRANSFER, 4'd9,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_CANCEL,   4'd5,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_TRANSFER, 4'd0,  1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_ENQUEUE,  4'd12, 1'b0, STATUS_DONE, 4'd0, 5'd0);
      add_row(KIND_TRANSFER, 4'd3,  1'b0, STATUS_DONE, 4'd0, 5'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);
      wait_until_drained();

      enq_w = 40;
      cancel_w = 30;
      xfer_w = 28;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = profile[p][0];
         stall_pct = profile[p][1];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            // Every hundred transactions switch between fill, drain and balanced mixes.
            if (n % 100 == 0) begin
               case ($urandom_range(2))
                  0: begin enq_w = 70; cancel_w = 15; xfer_w = 13; end
                  1: begin enq_w = 20; cancel_w = 35; xfer_w = 43; end
                  default: begin enq_w = 40; cancel_w = 30; xfer_w = 28; end
               endcase
            end
            if ($urandom_range(199) == 0) wait_until_drained();
            send_item(random_item(enq_w, cancel_w, xfer_w), 1'b0, '0);
         end
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d done, %0d nothing to do, %0d duplicate; longest queue %0d.",
               accepted, status_hits[STATUS_DONE], status_hits[STATUS_NOTHING],
               status_hits[STATUS_DUPLICATE], longest);
      $display("Cancels unlinked %0d head, %0d middle and %0d tail waiters; %0d mismatches.",
               cancel_head, cancel_mid, cancel_tail, mismatches);
      if (mismatches == 0 && queue_op_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/wq_pkg.sv
rtl/wq_ram.sv
rtl/wq_ctrl.sv
rtl/wq_dp.sv
rtl/fifo_waiter_queue_with_cancel.sv
tb/fifo_waiter_queue_with_cancel_tb.sv
